FILE: rtl/core/cdq_pkg.sv
// Shared types and constants for the circular deque unit.
`timescale 1ns / 1ps

package cdq_pkg;

   localparam int VALUE_W = 32;
   localparam int CAP_W   = 11;
   localparam int OP_W    = 3;

   localparam logic [CAP_W-1:0]   CAP_RESET   = 11'd1024;
   localparam logic [VALUE_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

   typedef enum logic [OP_W-1:0] {
      OP_NONE       = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_PUSH_REAR  = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_POP_REAR   = 3'd4
   } op_type;

   // Per-cycle command broadcast along one chain of cells.
   typedef struct packed {
      logic grow;    // shift toward the far end, cell zero takes the new value
      logic shrink;  // shift toward cell zero
      logic append;  // write the new value at the cell indexed by the count
   } chain_ctl_type;

endpackage

FILE: rtl/core/cdq_ifs.sv
// Request and response channel interfaces of the circular deque unit.
`timescale 1ns / 1ps

interface cdq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [cdq_pkg::OP_W-1:0]             operation;
   logic signed [cdq_pkg::VALUE_W-1:0]   value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

interface cdq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 ok;
   logic signed [cdq_pkg::VALUE_W-1:0]   front_value;
   logic signed [cdq_pkg::VALUE_W-1:0]   rear_value;
   logic                                 is_empty;
   logic                                 is_full;
   logic [cdq_pkg::CAP_W-1:0]            entry_count;

   modport source (output valid, output ok, output front_value, output rear_value,
                   output is_empty, output is_full, output entry_count, input ready);
   modport sink   (input valid, input ok, input front_value, input rear_value,
                   input is_empty, input is_full, input entry_count, output ready);
endinterface

FILE: rtl/core/cdq_cell.sv
// One storage cell of a deque chain: takes a neighbor's entry or the new value.
`timescale 1ns / 1ps

module cdq_cell #(
   parameter int CNT_W = 11,
   parameter int INDEX = 0
) (
   input  logic                          clock,
   input  cdq_pkg::chain_ctl_type        ctl,
   input  logic [CNT_W-1:0]              count,
   input  logic [cdq_pkg::VALUE_W-1:0]   fill_in,
   input  logic [cdq_pkg::VALUE_W-1:0]   left_in,
   input  logic [cdq_pkg::VALUE_W-1:0]   right_in,
   output logic [cdq_pkg::VALUE_W-1:0]   data_out
);

   logic [cdq_pkg::VALUE_W-1:0] data_ff;
   logic [cdq_pkg::VALUE_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      priority if (ctl.grow) begin
         data_in = left_in;
      end else if (ctl.shrink) begin
         data_in = right_in;
      end else if (ctl.append && (count == CNT_W'(INDEX))) begin
         data_in = fill_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

FILE: rtl/core/cdq_chain.sv
// Row of cells holding the deque in order, with one end fixed at cell zero.
`timescale 1ns / 1ps

module cdq_chain #(
   parameter int DEPTH = 1024,
   parameter int CNT_W = 11
) (
   input  logic                          clock,
   input  cdq_pkg::chain_ctl_type        ctl,
   input  logic [CNT_W-1:0]              count,
   input  logic [cdq_pkg::VALUE_W-1:0]   din,
   output logic [cdq_pkg::VALUE_W-1:0]   head
);

   logic [cdq_pkg::VALUE_W-1:0] cell_q [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [cdq_pkg::VALUE_W-1:0] left_data;
      logic [cdq_pkg::VALUE_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = din;
      end else begin : g_mid
         assign left_data = cell_q[i-1];
      end

      // The last cell has no right neighbor; a shrink there leaves a dead slot.
      if (i == DEPTH - 1) begin : g_last
         assign right_data = cell_q[i];
      end else begin : g_inner
         assign right_data = cell_q[i+1];
      end

      cdq_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .count    (count),
         .fill_in  (din),
         .left_in  (left_data),
         .right_in (right_data),
         .data_out (cell_q[i])
      );
   end

   assign head = cell_q[0];

endmodule

FILE: rtl/core/cdq_ctrl.sv
// Count, capacity register, command decode and response slot of the deque.
`timescale 1ns / 1ps

module cdq_ctrl #(
   parameter int DEPTH = 1024,
   parameter int CNT_W = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   cdq_req_if.sink                       req,
   cdq_rsp_if.source                     rsp,
   input  logic                          csr_wr_en,
   input  logic [cdq_pkg::CAP_W-1:0]     csr_wr_data,
   input  logic [cdq_pkg::VALUE_W-1:0]   front_q,
   input  logic [cdq_pkg::VALUE_W-1:0]   rear_q,
   output logic [CNT_W-1:0]              count,
   output cdq_pkg::chain_ctl_type        front_ctl,
   output cdq_pkg::chain_ctl_type        rear_ctl
);

   localparam int CMP_W = (CNT_W > cdq_pkg::CAP_W) ? CNT_W : cdq_pkg::CAP_W;

   logic [cdq_pkg::CAP_W-1:0] cap_ff;
   logic [cdq_pkg::CAP_W-1:0] cap_in;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      ok_ff;
   logic                      ok_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;

   logic [CMP_W-1:0]          cap_ext;
   logic [CMP_W-1:0]          eff_cap;
   logic [CMP_W-1:0]          count_ext;
   logic                      full;
   logic                      empty;
   logic                      accept;
   cdq_pkg::op_type           op;
   logic                      do_push_front;
   logic                      do_push_rear;
   logic                      do_pop_front;
   logic                      do_pop_rear;
   logic                      refused;

   // Clamp capacity to 1..DEPTH.
   always_comb begin
      cap_ext = CMP_W'(cap_ff);
      priority if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(DEPTH)) begin
         eff_cap = CMP_W'(DEPTH);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign count_ext = CMP_W'(count_ff);
   assign full      = (count_ext >= eff_cap);
   assign empty     = (count_ff == '0);

   // Hold new work while the response slot is occupied and not being taken.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign op        = cdq_pkg::op_type'(req.operation);

   always_comb begin
      do_push_front = 1'b0;
      do_push_rear  = 1'b0;
      do_pop_front  = 1'b0;
      do_pop_rear   = 1'b0;
      refused       = 1'b0;
      unique case (op)
         cdq_pkg::OP_PUSH_FRONT: begin
            do_push_front = accept && !full;
            refused       = full;
         end
         cdq_pkg::OP_PUSH_REAR: begin
            do_push_rear = accept && !full;
            refused      = full;
         end
         cdq_pkg::OP_POP_FRONT: begin
            do_pop_front = accept && !empty;
            refused      = empty;
         end
         cdq_pkg::OP_POP_REAR: begin
            do_pop_rear = accept && !empty;
            refused     = empty;
         end
         default: begin
            refused = 1'b0;
         end
      endcase
   end

   // Front chain keeps the front entry in cell zero, rear chain the rear entry.
   always_comb begin
      front_ctl.grow   = do_push_front;
      front_ctl.shrink = do_pop_front;
      front_ctl.append = do_push_rear;
      rear_ctl.grow    = do_push_rear;
      rear_ctl.shrink  = do_pop_rear;
      rear_ctl.append  = do_push_front;
   end

   always_comb begin
      cap_in       = cap_ff;
      count_in     = count_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      priority if (csr_wr_en) begin
         cap_in   = csr_wr_data;
         count_in = '0;
      end else if (do_push_front || do_push_rear) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop_front || do_pop_rear) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (accept) begin
         ok_in        = !refused;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= cdq_pkg::CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff <= ok_in;
   end

   assign count           = count_ff;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.ok          = ok_ff;
   assign rsp.is_empty    = empty;
   assign rsp.is_full     = full;
   assign rsp.entry_count = count_ext[cdq_pkg::CAP_W-1:0];
   assign rsp.front_value = empty ? cdq_pkg::EMPTY_VALUE : front_q;
   assign rsp.rear_value  = empty ? cdq_pkg::EMPTY_VALUE : rear_q;

   a_count_in_range : assert property (@(posedge clock) disable iff (reset)
      count_ext <= eff_cap)
      else $error("entry count above effective capacity");

   a_push_counts : assert property (@(posedge clock) disable iff (reset)
      (do_push_front || do_push_rear) && !csr_wr_en |=> count_ff == $past(count_ff) + 1'b1)
      else $error("accepted insert did not advance the count");

   a_csr_empties : assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> count_ff == '0)
      else $error("capacity write did not empty the deque");

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !accept)
      else $error("transaction accepted over a pending response");

endmodule

FILE: rtl/core/circular_deque_unit.sv
// Top level of the circular deque unit: control plus front and rear cell chains.
`timescale 1ns / 1ps

// A double-ended queue of up to DEPTH signed 32-bit entries, limited at run time
// by the capacity register (clamped to 1..DEPTH; any write empties the queue).
// The entries live in two chains of DEPTH cells each, one with the front entry
// at cell zero and one with the rear entry at cell zero, so every operation
// completes by shifting or writing cells in place. A request transaction is taken
// in any cycle in which the response slot is empty or its transaction completes,
// and its response appears in the next cycle: sustained rate is one operation per
// cycle while responses are taken, limited only by the single response register.
// Storage is 2 x DEPTH x 32 flip-flops; there is no clearing pass after reset.

module circular_deque_unit #(
   parameter int DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   cdq_req_if.sink                       req_chan,
   cdq_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [cdq_pkg::CAP_W-1:0]     csr_wr_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]              count;
   cdq_pkg::chain_ctl_type        front_ctl;
   cdq_pkg::chain_ctl_type        rear_ctl;
   logic [cdq_pkg::VALUE_W-1:0]   front_q;
   logic [cdq_pkg::VALUE_W-1:0]   rear_q;
   logic [cdq_pkg::VALUE_W-1:0]   new_value;

   assign new_value = req_chan.value;

   cdq_ctrl #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .front_q     (front_q),
      .rear_q      (rear_q),
      .count       (count),
      .front_ctl   (front_ctl),
      .rear_ctl    (rear_ctl)
   );

   cdq_chain #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W)
   ) u_front_chain (
      .clock (clock),
      .ctl   (front_ctl),
      .count (count),
      .din   (new_value),
      .head  (front_q)
   );

   cdq_chain #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W)
   ) u_rear_chain (
      .clock (clock),
      .ctl   (rear_ctl),
      .count (count),
      .din   (new_value),
      .head  (rear_q)
   );

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the circular deque unit: queued stimulus, shadow deque, checker.
`timescale 1ns / 1ps

module testbench;

   localparam int DEPTH         = 1024;
   localparam int IDX_W         = $clog2(DEPTH);
   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 12;
   localparam int MAX_WAIT      = 6;
   localparam int SETTLE_CYCLES = 2;
   localparam int TIMEOUT_NS    = 3_000_000;

   localparam int VALUE_W = cdq_pkg::VALUE_W;
   localparam int CAP_W   = cdq_pkg::CAP_W;
   localparam int OP_W    = cdq_pkg::OP_W;

   localparam logic [OP_W-1:0]    OP_FIRST_RESERVED = 3'd5;
   localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;

   typedef enum logic [1:0] {
      CMD_OP,
      CMD_CAPACITY,
      CMD_DRAIN
   } deque_cmd_kind_type;

   typedef struct packed {
      deque_cmd_kind_type   kind;
      logic [OP_W-1:0]      op_code;
      logic [VALUE_W-1:0]   value;
      logic [CAP_W-1:0]     capacity;
   } deque_cmd_type;

   typedef struct packed {
      logic                 ok;
      logic [VALUE_W-1:0]   front_value;
      logic [VALUE_W-1:0]   rear_value;
      logic                 is_empty;
      logic                 is_full;
      logic [CAP_W-1:0]     entry_count;
   } deque_rsp_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   cdq_req_if req_if ();
   cdq_rsp_if rsp_if ();

   circular_deque_unit #(.DEPTH(DEPTH)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the deque
   logic [VALUE_W-1:0] shadow_ring [DEPTH];
   logic [IDX_W-1:0]   shadow_head;
   logic [IDX_W-1:0]   shadow_tail;
   logic [CAP_W-1:0]   shadow_count;
   logic [CAP_W-1:0]   shadow_capacity;

   deque_cmd_type  deque_cmd_q [$];
   deque_rsp_type  expected_rsp_q [$];

   int unsigned send_gap;
   int unsigned quiet_edges;
   int unsigned rsp_stall;
   bit          sender_burst;
   bit          receiver_burst;
   int unsigned ops_sent;
   int unsigned rsp_checked;
   int unsigned refused_seen;
   int unsigned full_seen;
   int unsigned deepest_fill;
   int unsigned capacity_writes;
   int unsigned error_count;

   always #(HALF_PERIOD) clock = ~clock;

   function automatic logic [CAP_W-1:0] live_capacity();
      if (shadow_capacity == '0) return CAP_W'(1);
      if (shadow_capacity > DEPTH) return CAP_W'(DEPTH);
      return shadow_capacity;
   endfunction

   function automatic logic [IDX_W-1:0] ring_back(logic [IDX_W-1:0] idx, logic [CAP_W-1:0] cap);
      return (idx == '0) ? IDX_W'(cap - 1) : idx - 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] ring_fwd(logic [IDX_W-1:0] idx, logic [CAP_W-1:0] cap);
      return (CAP_W'(idx) + 1 >= cap) ? '0 : idx + 1'b1;
   endfunction

   // Apply one operation to the shadow deque and return the response it must produce.
   function automatic deque_rsp_type apply_deque_op(logic [OP_W-1:0] op_code,
                                                    logic [VALUE_W-1:0] v);
      logic [CAP_W-1:0] cap;
      deque_rsp_type    r;
      cap  = live_capacity();
      r.ok = 1'b1;
      case (op_code)
         cdq_pkg::OP_PUSH_FRONT: begin
            if (shadow_count >= cap) begin
               r.ok = 1'b0;
            end else begin
               shadow_head = ring_back(shadow_head, cap);
               shadow_ring[shadow_head] = v;
               shadow_count++;
            end
         end
         cdq_pkg::OP_PUSH_REAR: begin
            if (shadow_count >= cap) begin
               r.ok = 1'b0;
            end else begin
               shadow_ring[shadow_tail] = v;
               shadow_tail = ring_fwd(shadow_tail, cap);
               shadow_count++;
            end
         end
         cdq_pkg::OP_POP_FRONT: begin
            if (shadow_count == '0) begin
               r.ok = 1'b0;
            end else begin
               shadow_head = ring_fwd(shadow_head, cap);
               shadow_count--;
            end
         end
         cdq_pkg::OP_POP_REAR: begin
            if (shadow_count == '0) begin
               r.ok = 1'b0;
            end else begin
               shadow_tail = ring_back(shadow_tail, cap);
               shadow_count--;
            end
         end
         default: begin
         end
      endcase
      r.is_empty    = (shadow_count == '0);
      r.is_full     = (shadow_count >= cap);
      r.entry_count = shadow_count;
      if (r.is_empty) begin
         r.front_value = cdq_pkg::EMPTY_VALUE;
         r.rear_value  = cdq_pkg::EMPTY_VALUE;
      end else begin
         r.front_value = shadow_ring[shadow_head];
         r.rear_value  = shadow_ring[ring_back(shadow_tail, cap)];
      end
      return r;
   endfunction

   task automatic check_field(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
   endtask

   task automatic push_op(logic [OP_W-1:0] op_code, logic [VALUE_W-1:0] v);
      deque_cmd_type cmd;
      cmd.kind     = CMD_OP;
      cmd.op_code  = op_code;
      cmd.value    = v;
      cmd.capacity = '0;
      deque_cmd_q.push_back(cmd);
   endtask

   task automatic push_capacity(logic [CAP_W-1:0] cap);
      deque_cmd_type cmd;
      cmd.kind     = CMD_CAPACITY;
      cmd.op_code  = cdq_pkg::OP_NONE;
      cmd.value    = '0;
      cmd.capacity = cap;
      deque_cmd_q.push_back(cmd);
   endtask

   // One capacity setting followed by a run that swings between empty and full.
   task automatic queue_random_phase(logic [CAP_W-1:0] cap_setting, int unsigned n_ops,
                                     int unsigned follow_pct);
      int unsigned      live;
      int unsigned      held;
      bit               filling;
      bit               is_push;
      logic [OP_W-1:0]  op_code;
      logic [VALUE_W-1:0] v;
      deque_cmd_type    pause;
      push_capacity(cap_setting);
      live    = (cap_setting == '0) ? 1 : (cap_setting > DEPTH) ? DEPTH : cap_setting;
      held    = 0;
      filling = 1'b1;
      pause   = '0;
      pause.kind = CMD_DRAIN;
      for (int i = 0; i < n_ops; i++) begin
         // hold the sender until every response is back
         if (i == n_ops / 2) deque_cmd_q.push_back(pause);
         case ($urandom_range(0, 7))
            0:       v = VAL_MAX;
            1:       v = VAL_MIN;
            2:       v = '0;
            3:       v = '1;
            default: v = $urandom;
         endcase
         if ($urandom_range(0, 19) == 0) begin
            op_code = ($urandom_range(0, 3) == 0) ? cdq_pkg::OP_NONE
                      : OP_W'(OP_FIRST_RESERVED + $urandom_range(0, 2));
         end else begin
            is_push = (($urandom_range(1, 100) <= follow_pct) == filling);
            if (is_push) begin
               op_code = $urandom_range(0, 1) ? cdq_pkg::OP_PUSH_FRONT : cdq_pkg::OP_PUSH_REAR;
               if (held < live) held++;
            end else begin
               op_code = $urandom_range(0, 1) ? cdq_pkg::OP_POP_FRONT : cdq_pkg::OP_POP_REAR;
               if (held > 0) held--;
            end
         end
         push_op(op_code, v);
         if (filling && held == live && $urandom_range(0, 2) == 0) filling = 1'b0;
         else if (!filling && held == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
         else if (live <= 64 && $urandom_range(0, 49) == 0) filling = !filling;
      end
   endtask

   // Request driver
   always @(posedge clock) begin
      deque_cmd_type cmd;
      logic          presenting;
      logic          write_now;
      write_now = 1'b0;
      if (reset) begin
         req_if.valid     <= 1'b0;
         req_if.operation <= cdq_pkg::OP_NONE;
         req_if.value     <= '0;
         csr_wr_en        <= 1'b0;
         csr_wr_data      <= '0;
         send_gap         = 0;
         quiet_edges      = 0;
         shadow_head      = '0;
         shadow_tail      = '0;
         shadow_count     = '0;
         shadow_capacity  = cdq_pkg::CAP_RESET;
      end else begin
         presenting = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            expected_rsp_q.push_back(apply_deque_op(req_if.operation, req_if.value));
            ops_sent++;
            presenting = 1'b0;
            if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
            send_gap = sender_burst ? 0 : $urandom_range(0, MAX_WAIT);
         end
         quiet_edges = (presenting || expected_rsp_q.size() != 0) ? 0 : quiet_edges + 1;
         if (!presenting && deque_cmd_q.size() != 0) begin
            if (deque_cmd_q[0].kind == CMD_OP) begin
               if (send_gap > 0) begin
                  send_gap--;
               end else begin
                  cmd = deque_cmd_q.pop_front();
                  req_if.operation <= cmd.op_code;
                  req_if.value     <= cmd.value;
                  presenting       = 1'b1;
               end
            end else if (quiet_edges >= SETTLE_CYCLES) begin
               cmd = deque_cmd_q.pop_front();
               if (cmd.kind == CMD_CAPACITY) begin
                  // a capacity write also empties the deque
                  write_now       = 1'b1;
                  csr_wr_data     <= cmd.capacity;
                  shadow_capacity = cmd.capacity;
                  shadow_head     = '0;
                  shadow_tail     = '0;
                  shadow_count    = '0;
                  capacity_writes++;
               end
               quiet_edges = 0;
            end
         end
         req_if.valid <= presenting;
         csr_wr_en    <= write_now;
      end
   end

   // Response monitor and checker
   always @(posedge clock) begin
      deque_rsp_type want;
      deque_rsp_type got;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.ok          = rsp_if.ok;
            got.front_value = rsp_if.front_value;
            got.rear_value  = rsp_if.rear_value;
            got.is_empty    = rsp_if.is_empty;
            got.is_full     = rsp_if.is_full;
            got.entry_count = rsp_if.entry_count;
            if (expected_rsp_q.size() == 0) begin
               error_count++;
               $display("%0t ns: response transaction with none expected, got 0x%0h",
                        $time, got);
            end else begin
               want = expected_rsp_q.pop_front();
               rsp_checked++;
               if (!want.ok) refused_seen++;
               if (want.is_full) full_seen++;
               if (want.entry_count > deepest_fill) deepest_fill = want.entry_count;
               check_field("ok", VALUE_W'(want.ok), VALUE_W'(got.ok));
               check_field("front_value", want.front_value, got.front_value);
               check_field("rear_value", want.rear_value, got.rear_value);
               check_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(got.is_empty));
               check_field("is_full", VALUE_W'(want.is_full), VALUE_W'(got.is_full));
               check_field("entry_count", VALUE_W'(want.entry_count),
                           VALUE_W'(got.entry_count));
            end
            if ($urandom_range(0, 39) == 0) receiver_burst = !receiver_burst;
            rsp_stall = receiver_burst ? 0 : $urandom_range(0, MAX_WAIT);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_if.ready <= (rsp_stall == 0);
      end
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.operation = cdq_pkg::OP_NONE;
      req_if.value     = '0;
      rsp_if.ready     = 1'b0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;

      // Directed: empty deque at reset capacity
      push_op(cdq_pkg::OP_POP_FRONT, '0);
      push_op(cdq_pkg::OP_POP_REAR, '0);
      push_op(cdq_pkg::OP_NONE, VAL_MAX);
      push_op(cdq_pkg::OP_PUSH_FRONT, VAL_MAX);
      push_op(cdq_pkg::OP_PUSH_REAR, VAL_MIN);
      // a held all-ones entry is not emptiness
      push_op(cdq_pkg::OP_PUSH_FRONT, cdq_pkg::EMPTY_VALUE);
      push_op(OP_FIRST_RESERVED, '1);
      push_op(OP_FIRST_RESERVED + 3'd1, '0);
      push_op(OP_FIRST_RESERVED + 3'd2, VAL_MIN);
      push_op(cdq_pkg::OP_POP_REAR, '0);
      push_op(cdq_pkg::OP_POP_FRONT, '0);
      push_op(cdq_pkg::OP_POP_FRONT, '0);
      push_op(cdq_pkg::OP_POP_FRONT, '0);
      // single-slot deque
      push_capacity(11'd1);
      push_op(cdq_pkg::OP_PUSH_REAR, 32'h1234_5678);
      push_op(cdq_pkg::OP_PUSH_FRONT, 32'h0BAD_F00D);
      push_op(cdq_pkg::OP_PUSH_REAR, 32'h0BAD_F00D);
      push_op(cdq_pkg::OP_POP_FRONT, '0);
      push_op(cdq_pkg::OP_POP_REAR, '0);
      // zero capacity acts as one slot
      push_capacity(11'd0);
      push_op(cdq_pkg::OP_PUSH_FRONT, 32'hA5A5_5A5A);
      push_op(cdq_pkg::OP_PUSH_REAR, 32'h5A5A_A5A5);
      push_op(cdq_pkg::OP_POP_REAR, '0);
      // wrap the head pointer in a three-slot deque, leave one entry for the next write
      push_capacity(11'd3);
      push_op(cdq_pkg::OP_PUSH_FRONT, 32'h0000_0001);
      push_op(cdq_pkg::OP_PUSH_REAR, 32'h0000_0002);
      push_op(cdq_pkg::OP_PUSH_FRONT, 32'h0000_0003);
      push_op(cdq_pkg::OP_PUSH_REAR, 32'h0000_0004);
      push_op(cdq_pkg::OP_POP_REAR, '0);
      push_op(cdq_pkg::OP_POP_FRONT, '0);

      // Random phases
      queue_random_phase(11'd1, 80, 60);
      queue_random_phase(11'd2, 80, 60);
      queue_random_phase(11'd0, 60, 60);
      queue_random_phase(11'd5, 100, 75);
      repeat (4) queue_random_phase(CAP_W'($urandom_range(1, 40)), 100, 75);
      // above DEPTH clamps to DEPTH
      queue_random_phase(11'h7FF, 400, 96);
      queue_random_phase(CAP_W'(DEPTH), 60, 70);
      queue_random_phase(CAP_W'($urandom_range(6, 20)), 100, 75);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (deque_cmd_q.size() != 0 || req_if.valid || expected_rsp_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES + 3) @(negedge clock);

      $display("Checked %0d of %0d deque operations over %0d capacity writes.",
               rsp_checked, ops_sent, capacity_writes);
      $display("Refused: %0d, responses at full: %0d, deepest fill: %0d entries.",
               refused_seen, full_seen, deepest_fill);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timeout: %0d operations sent, %0d responses checked", ops_sent, rsp_checked);
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: circular_deque_unit.f
rtl/core/cdq_pkg.sv
rtl/core/cdq_ifs.sv
rtl/core/cdq_cell.sv
rtl/core/cdq_chain.sv
rtl/core/cdq_ctrl.sv
rtl/core/circular_deque_unit.sv
tb/sv/testbench.sv
